FILE: sv/mbps_pkg.sv
// Shared widths and register codes for the masked byte pattern scanner.
package mbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 64;
  localparam int WORD_BYTES = 8;
  localparam int REG_WORDS  = 4;
  localparam int WORD_W     = WORD_BYTES * BYTE_W;
  localparam int OFFSET_W   = 32;
  localparam int WORDS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PATTERN_WORD_0     = 3'd0;
  localparam cfg_idx_t CFG_PATTERN_WORD_1     = 3'd1;
  localparam cfg_idx_t CFG_PATTERN_WORD_2     = 3'd2;
  localparam cfg_idx_t CFG_PATTERN_WORD_3     = 3'd3;
  localparam cfg_idx_t CFG_PATTERN_WORDS_USED = 3'd4;
  localparam cfg_idx_t CFG_RESULT_OFFSET      = 3'd5;

endpackage

FILE: sv/mbps_in_if.sv
// Byte stream channel into the scanner.
interface mbps_in_if;
  import mbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [ADDR_W-1:0] byte_address;
  logic              may_start;
  logic              run_start;
  logic              new_scan;
  logic              end_of_scan;

  modport source (output valid, data_byte, byte_address, may_start, run_start,
                  new_scan, end_of_scan, input ready);
  modport sink (input valid, data_byte, byte_address, may_start, run_start,
                new_scan, end_of_scan, output ready);
endinterface

FILE: sv/mbps_out_if.sv
// Scan result channel out of the scanner.
interface mbps_out_if;
  import mbps_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink (input valid, found, match_address, output ready);
endinterface

FILE: sv/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: byte window, masked compare and result latch.
//
// Usage: bytes of the scanned region arrive on byte_ch, one item per byte,
// each with its address and flags. run_start empties the window, new_scan
// clears the latched match, may_start marks bytes where a match may begin.
// The pattern (whole 8-byte words, zero bytes are wildcards), its length and
// the signed result offset are set through the cfg write port while idle.
// An item with end_of_scan produces one item on result_ch: found and the
// first match's start address plus offset (0 when nothing was found).
// Throughput: one byte per cycle while byte_ch ready is high. A byte is shifted
// into the window when it is accepted, then compared against the pattern in the
// compare stage, and a result is presented once its end_of_scan byte leaves it.
// The compare/latch stage is the only loop: every byte's match check reads
// the latch left by the byte before it.
// If result_ch stalls while a result waits, the block still takes bytes
// until a second end_of_scan byte reaches the compare stage; then byte_ch
// ready drops until the result register frees.
// Reset clears the pattern to all wildcards of one word, the offset to 0,
// the window fill, the latch and all valid flags.
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  mbps_pkg::cfg_idx_t                  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  mbps_in_if.sink                             byte_ch,
  mbps_out_if.source                          result_ch
);
  import mbps_pkg::*;

  localparam int MAX_WORDS_RAW = MAX_PATTERN_BYTES / WORD_BYTES;
  localparam int MAX_WORDS     = (MAX_WORDS_RAW < REG_WORDS) ? MAX_WORDS_RAW : REG_WORDS;
  localparam int FILL_W        = $clog2(MAX_PATTERN_BYTES + 1);

  // configuration
  logic [WORD_W-1:0]   pattern_word [REG_WORDS];
  logic [WORDS_W-1:0]  pattern_words_used;
  logic [OFFSET_W-1:0] result_offset;

  // window stage
  logic [BYTE_W-1:0]            window_bytes [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] window_start_flags;
  logic [FILL_W-1:0]            window_fill;
  logic                         b_valid;
  logic                         b_new_scan;
  logic                         b_end;
  logic [ADDR_W-1:0]            b_address;

  // compare stage
  logic              match_latched;
  logic [ADDR_W-1:0] latched_address;

  // result register
  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_address;

  logic [WORDS_W-1:0]   words_eff;
  logic [ADDR_W-1:0]    addr_adjust;
  logic                 b_adv;
  logic                 in_fire;
  logic                 b_fire;
  logic [MAX_WORDS-1:0] match_len;
  logic                 match_sel;
  logic                 latch_eff;
  logic                 hit;
  logic                 latched_next;
  logic [ADDR_W-1:0]    latched_address_next;
  logic [FILL_W-1:0]    fill_base;

  always_comb begin
    if (pattern_words_used == '0) begin
      words_eff = WORDS_W'(1);
    end else if (pattern_words_used > WORDS_W'(MAX_WORDS)) begin
      words_eff = WORDS_W'(MAX_WORDS);
    end else begin
      words_eff = pattern_words_used;
    end
  end

  // start = address - (length - 1), then add the sign-extended offset
  assign addr_adjust = {{(ADDR_W-OFFSET_W){result_offset[OFFSET_W-1]}}, result_offset}
                       - (ADDR_W'({words_eff, 3'b000}) - ADDR_W'(1));

  assign b_adv   = !b_valid || !b_end || !out_valid || result_ch.ready;
  assign in_fire = byte_ch.valid && byte_ch.ready;
  assign b_fire  = b_valid && b_adv;
  assign byte_ch.ready = b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < REG_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_words_used <= WORDS_W'(1);
      result_offset      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_WORD_0:     pattern_word[0] <= cfg_data;
        CFG_PATTERN_WORD_1:     pattern_word[1] <= cfg_data;
        CFG_PATTERN_WORD_2:     pattern_word[2] <= cfg_data;
        CFG_PATTERN_WORD_3:     pattern_word[3] <= cfg_data;
        CFG_PATTERN_WORDS_USED: pattern_words_used <= cfg_data[WORDS_W-1:0];
        CFG_RESULT_OFFSET:      result_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign fill_base = byte_ch.run_start ? '0 : window_fill;

  // window shift on accept; entries past the fill are never looked at
  always_ff @(posedge clk) begin
    if (in_fire) begin
      window_bytes[0] <= byte_ch.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
        window_bytes[k] <= window_bytes[k-1];
      end
      window_start_flags <= {window_start_flags[MAX_PATTERN_BYTES-2:0], byte_ch.may_start};
      b_new_scan <= byte_ch.new_scan;
      b_end      <= byte_ch.end_of_scan;
      b_address  <= byte_ch.byte_address + addr_adjust;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      b_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        window_fill <= (fill_base == FILL_W'(MAX_PATTERN_BYTES)) ? fill_base
                                                                  : fill_base + FILL_W'(1);
      end
      if (in_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
    end
  end

  // one masked compare per supported pattern length
  always_comb begin
    logic              ok;
    logic [BYTE_W-1:0] pb;
    for (int l = 1; l <= MAX_WORDS; l++) begin
      ok = (window_fill >= FILL_W'(WORD_BYTES * l))
           && window_start_flags[WORD_BYTES*l-1];
      for (int i = 0; i < WORD_BYTES * l; i++) begin
        pb = pattern_word[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
        if (pb != '0 && pb != window_bytes[WORD_BYTES*l-1-i]) begin
          ok = 1'b0;
        end
      end
      match_len[l-1] = ok;
    end
  end

  always_comb begin
    match_sel = 1'b0;
    for (int l = 1; l <= MAX_WORDS; l++) begin
      if (words_eff == WORDS_W'(l)) begin
        match_sel = match_len[l-1];
      end
    end
  end

  assign latch_eff            = match_latched && !b_new_scan;
  assign hit                  = !latch_eff && match_sel;
  assign latched_next         = latch_eff || hit;
  assign latched_address_next = hit ? b_address : latched_address;

  always_ff @(posedge clk) begin
    if (b_fire) begin
      latched_address <= latched_address_next;
    end
    if (b_fire && b_end) begin
      out_found   <= latched_next;
      out_address <= latched_next ? latched_address_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (b_fire) begin
        match_latched <= latched_next;
      end
      if (b_fire && b_end) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.found         = out_found;
  assign result_ch.match_address = out_address;

  a_accept_reaches_compare: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> b_valid)
    else $error("accepted byte did not reach the compare stage");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FILL_W'(MAX_PATTERN_BYTES))
    else $error("window fill beyond window depth");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_end && out_valid && !result_ch.ready |-> !byte_ch.ready)
    else $error("byte taken while a result is blocked");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_address == '0)
    else $error("nonzero address on a not-found result");

endmodule

FILE: tb/scan_checker.sv
// Scan result checker: watches the register port and both channels, predicts and compares.
module scan_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  mbps_pkg::cfg_idx_t            cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  mbps_in_if                            byte_ch,
  mbps_out_if                           result_ch,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbps_pkg::*;

  // window depth of the block as instantiated (default parameter)
  localparam int MAX_BYTES = 32;
  localparam int MAX_WORDS = (MAX_BYTES / WORD_BYTES < REG_WORDS) ?
                             MAX_BYTES / WORD_BYTES : REG_WORDS;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } scan_result_t;

  logic [WORD_W-1:0]   pat_word [REG_WORDS];
  logic [WORDS_W-1:0]  pat_words;
  logic [OFFSET_W-1:0] res_offset;
  logic [BYTE_W-1:0]   window_data [MAX_BYTES];
  logic                window_flag [MAX_BYTES];
  int unsigned         window_fill;
  logic                hit_latched;
  logic [ADDR_W-1:0]   hit_address;
  scan_result_t        predicted_scans [$];
  int                  fails = 0;
  int                  depth = 0;

  assign mismatches = fails;
  assign pending    = depth;

  function automatic int unsigned pattern_len();
    int unsigned w;
    w = 32'(pat_words);
    if (w < 1) w = 1;
    if (w > MAX_WORDS) w = MAX_WORDS;
    return w * WORD_BYTES;
  endfunction

  // window_data[k] holds the byte k items back; the oldest byte of a
  // candidate match sits at plen-1 and lines up with pattern byte 0
  function automatic logic window_hit(input int unsigned plen);
    logic [BYTE_W-1:0] p;
    if (window_fill < plen) return 1'b0;
    if (!window_flag[plen-1]) return 1'b0;
    for (int i = 0; i < plen; i++) begin
      p = pat_word[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
      if (p != '0 && p != window_data[plen-1-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] d, input logic [ADDR_W-1:0] a,
                                    input logic ms, input logic rs, input logic ns,
                                    input logic eos);
    int unsigned  plen;
    scan_result_t r;
    plen = pattern_len();
    if (ns) begin
      hit_latched = 1'b0;
      hit_address = '0;
    end
    if (rs) window_fill = 0;
    for (int k = MAX_BYTES - 1; k > 0; k--) begin
      window_data[k] = window_data[k-1];
      window_flag[k] = window_flag[k-1];
    end
    window_data[0] = d;
    window_flag[0] = ms;
    if (window_fill < MAX_BYTES) window_fill++;
    if (!hit_latched && window_hit(plen)) begin
      hit_address = a - ADDR_W'(plen - 1)
                  + {{(ADDR_W-OFFSET_W){res_offset[OFFSET_W-1]}}, res_offset};
      hit_latched = 1'b1;
    end
    if (eos) begin
      r.found         = hit_latched;
      r.match_address = hit_latched ? hit_address : '0;
      predicted_scans = {predicted_scans, r};
    end
  endfunction

  always @(posedge clk) begin : watch
    scan_result_t want;
    if (rst) begin
      for (int i = 0; i < REG_WORDS; i++) pat_word[i] = '0;
      pat_words  = WORDS_W'(1);
      res_offset = '0;
      for (int k = 0; k < MAX_BYTES; k++) begin
        window_data[k] = '0;
        window_flag[k] = 1'b0;
      end
      window_fill = 0;
      hit_latched = 1'b0;
      hit_address = '0;
      predicted_scans.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_WORD_0, CFG_PATTERN_WORD_1, CFG_PATTERN_WORD_2, CFG_PATTERN_WORD_3:
            pat_word[2'(cfg_index - CFG_PATTERN_WORD_0)] = cfg_data[WORD_W-1:0];
          CFG_PATTERN_WORDS_USED: pat_words  = cfg_data[WORDS_W-1:0];
          CFG_RESULT_OFFSET:      res_offset = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      // results trail their bytes, so compare before taking this edge's byte
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_scans.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing expected: found %0b match_address %h",
                     $time, result_ch.found, result_ch.match_address);
        end else begin
          want = predicted_scans.pop_front();
          if (result_ch.found !== want.found ||
              result_ch.match_address !== want.match_address) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result mismatch: found exp %0b got %0b, match_address exp %h got %h",
                       $time, want.found, result_ch.found, want.match_address,
                       result_ch.match_address);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        scan_byte(byte_ch.data_byte, byte_ch.byte_address, byte_ch.may_start,
                  byte_ch.run_start, byte_ch.new_scan, byte_ch.end_of_scan);
    end
    depth = predicted_scans.size();
  end

endmodule

FILE: tb/testbench.sv
// Scanner testbench top: clock, reset, register writes, byte stream stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbps_pkg::*;

  localparam int ITEM_TARGET = 700;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_BYTES   = 32;
  localparam cfg_idx_t CFG_NO_REG = 3'd7;  // no register decodes here

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  int                    cycles = 0;
  int                    items_sent = 0;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    words_used = 1;
  int                    pat_len = WORD_BYTES;
  logic [BYTE_W-1:0]     pat_bytes [MAX_BYTES];

  mbps_in_if  byte_ch();
  mbps_out_if result_ch();

  masked_byte_pattern_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  scan_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_ch    (byte_ch),
    .result_ch  (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller drives the next item or drops valid
  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic [ADDR_W-1:0] a,
                           input logic ms, input logic rs, input logic ns, input logic eos);
    // no idling in the last part of the run
    if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= d;
    byte_ch.byte_address <= a;
    byte_ch.may_start    <= ms;
    byte_ch.run_start    <= rs;
    byte_ch.new_scan     <= ns;
    byte_ch.end_of_scan  <= eos;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // drop valid, drain results, then give the compare stage time to finish
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  task automatic random_config(input bit all_regs);
    logic [WORD_W-1:0]     w;
    logic [CFG_DATA_W-1:0] v;
    bit                    blank;
    int                    r;
    blank = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < REG_WORDS; i++) begin
      if (all_regs || $urandom_range(0, 2) != 0) begin
        for (int b = 0; b < WORD_BYTES; b++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: w[b*BYTE_W +: BYTE_W] = 8'h00;
            3:       w[b*BYTE_W +: BYTE_W] = 8'hFF;
            4:       w[b*BYTE_W +: BYTE_W] = 8'h01;
            default: w[b*BYTE_W +: BYTE_W] = BYTE_W'($urandom);
          endcase
          if (blank) w[b*BYTE_W +: BYTE_W] = '0;
          pat_bytes[i*WORD_BYTES + b] = w[b*BYTE_W +: BYTE_W];
        end
        write_reg(cfg_idx_t'(CFG_PATTERN_WORD_0 + i), w);
      end
    end
    if (all_regs || $urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 15);
      // most often one word; zero and oversized lengths now and then
      words_used = (r < 6) ? 1 : (r < 8) ? 0 : (r < 11) ? 2 : $urandom_range(3, 7);
      v = {$urandom, $urandom};
      v[WORDS_W-1:0] = words_used[WORDS_W-1:0];
      write_reg(CFG_PATTERN_WORDS_USED, v);
    end
    pat_len = WORD_BYTES * ((words_used < 1) ? 1 :
                            (words_used > REG_WORDS) ? REG_WORDS : words_used);
    if (all_regs || $urandom_range(0, 2) == 0) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       v[OFFSET_W-1:0] = 32'h8000_0000;
        1:       v[OFFSET_W-1:0] = 32'h7FFF_FFFF;
        2:       v[OFFSET_W-1:0] = '0;
        3:       v[OFFSET_W-1:0] = '1;
        default: ;
      endcase
      write_reg(CFG_RESULT_OFFSET, v);
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // one scan: a few contiguous runs, each usually carrying one planted
  // pattern copy with random wildcard bytes, sometimes broken
  task automatic run_scan();
    int                runs, len, at, flip;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] d;
    bit                fresh;
    runs  = $urandom_range(1, 3);
    fresh = ($urandom_range(0, 6) != 0);
    for (int r = 0; r < runs; r++) begin
      case ($urandom_range(0, 5))
        0:       a = '1 - ADDR_W'($urandom_range(0, 40));
        1:       a = ADDR_W'($urandom_range(0, 40));
        default: a = {$urandom, $urandom};
      endcase
      len  = $urandom_range(1, pat_len + 12);
      at   = (len > pat_len) ? $urandom_range(0, len - pat_len) : 0;
      flip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pat_len - 1) : -1;
      for (int j = 0; j < len; j++) begin
        d = BYTE_W'($urandom);
        if (j >= at && j < at + pat_len && pat_bytes[j-at] != '0) d = pat_bytes[j-at];
        if (flip >= 0 && j == at + flip) d = d ^ BYTE_W'($urandom_range(1, 255));
        send_byte(d, a,
                  (j == at) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 3) == 0),
                  j == 0 || $urandom_range(0, 49) == 0,
                  (r == 0 && j == 0 && fresh) || $urandom_range(0, 59) == 0,
                  (r == runs - 1 && j == len - 1) || $urandom_range(0, 79) == 0);
        a = ($urandom_range(0, 39) == 0) ? {$urandom, $urandom} : a + 1;
      end
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    logic [BYTE_W-1:0] d;
    bit                first;
    cfg_we               = 1'b0;
    cfg_index            = CFG_PATTERN_WORD_0;
    cfg_data             = '0;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = '0;
    byte_ch.byte_address = '0;
    byte_ch.may_start    = 1'b0;
    byte_ch.run_start    = 1'b0;
    byte_ch.new_scan     = 1'b0;
    byte_ch.end_of_scan  = 1'b0;
    for (int i = 0; i < MAX_BYTES; i++) pat_bytes[i] = '0;
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset pattern is one wildcard word: three bytes are too few to match
    send_byte(8'h00, '0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_byte(8'hFF, 64'd1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_byte(8'h5A, 64'd2, 1'b0, 1'b0, 1'b0, 1'b1);
    settle();
    write_reg(CFG_PATTERN_WORD_0, 64'hFF00_0000_0000_0001);
    write_reg(CFG_PATTERN_WORD_1, '1);
    write_reg(CFG_PATTERN_WORD_2, '1);
    write_reg(CFG_PATTERN_WORD_3, '1);
    write_reg(CFG_PATTERN_WORDS_USED, '0);  // zero length acts as one word
    write_reg(CFG_RESULT_OFFSET, 64'h0000_0000_8000_0000);
    cfg_we <= 1'b0;
    // first candidate start is not permitted; the match begins one byte
    // later and runs across the top of the address space
    base = 64'hFFFF_FFFF_FFFF_FFFC;
    for (int j = 0; j < 10; j++) begin
      d = (j < 2) ? 8'h01 : (j == 8) ? 8'hFF : (j == 9) ? 8'h00 : 8'hAA;
      send_byte(d, base + ADDR_W'(j), j == 1, j == 0, j == 0, j == 9);
    end
    // latch holds past end of scan until a new scan clears it
    send_byte(8'h01, base + 64'd10, 1'b1, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, base + 64'd11, 1'b1, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, base + 64'd12, 1'b0, 1'b0, 1'b1, 1'b1);

    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      settle();
      random_config(first);
      first = 1'b0;
      if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      repeat ($urandom_range(2, 6)) run_scan();
    end
    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
